// File: design/kll_pkg.sv
// ----------------------------------------------------------------------------
// kll_pkg: shared types and constants of the KLL quantile sketch
// Widths, limits and register indexes used by the interfaces and the core.
// ----------------------------------------------------------------------------
`default_nettype none
package kll_pkg;
  localparam int VALUE_WIDTH  = 32;
  localparam int MAX_LEVELS   = 16;
  localparam int LEVEL_DEPTH  = 256;
  localparam int LVL_W        = $clog2(MAX_LEVELS);
  localparam int POS_W        = $clog2(LEVEL_DEPTH);
  localparam int LEN_W        = POS_W + 1;
  localparam int CNT_W        = 5;
  localparam int WEIGHT_W     = 48;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHRINK_RATIO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED  = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [VALUE_WIDTH-1:0] sample_value;
  } request_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] rank_estimate;
    logic [WEIGHT_W-1:0] total_weight;
    logic [CNT_W-1:0]    levels_in_use;
    logic                overflow_flag;
  } result_t;
endpackage
`default_nettype wire

// File: design/kll_if.sv
// ----------------------------------------------------------------------------
// kll_if: valid/ready channels of the sketch
// One interface for requests and one for results.
// ----------------------------------------------------------------------------
`default_nettype none
interface kll_req_if;
  logic              valid;
  logic              ready;
  kll_pkg::request_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface kll_res_if;
  logic             valid;
  logic             ready;
  kll_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/kll_quantile_sketch.sv
// ----------------------------------------------------------------------------
// kll_quantile_sketch: KLL quantile sketch over unsigned 32-bit values
// Sorted levels in one memory, walked entry by entry by a sequencer.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on req: command 0 inserts sample_value, command 1
// asks for its weighted rank. An insert gives no result; a query gives one
// result on res with the rank, item count, level count and overflow flag.
// The user writes registers on cfg only while idle; the block does not check.
// Timing. The block takes one request at a time and drops ready until it is
// done. A sorted insert walks the level from its end, shifting each larger
// entry up. Each level check computes its capacity with up to MAX_LEVELS-1
// shared 24x16 multiplies, one per cycle. A compaction re-inserts every
// second entry one by one into the level above (the top level, when no level
// can be added, keeps them in place); a query reads every stored entry once.
// The single memory port per cycle sets the pace of these walks.
// Reset. Levels are emptied through the length registers, the level count
// becomes one and registers and LFSR reset to defaults; no clearing is needed.
// Stall. A finished result waits in the output register until taken; the next
// request is accepted only after that.
// ----------------------------------------------------------------------------
`default_nettype none
module kll_quantile_sketch (
  input  wire logic                               clk,
  input  wire logic                               rst,
  kll_req_if.sink                                 req,
  kll_res_if.source                               res,
  input  wire logic                               cfg_write,
  input  wire logic [kll_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [kll_pkg::CFG_DATA_W-1:0]     cfg_data
);
  localparam int VW = kll_pkg::VALUE_WIDTH;
  localparam int LW = kll_pkg::LVL_W;
  localparam int PW = kll_pkg::POS_W;
  localparam int NW = kll_pkg::LEN_W;
  localparam int WW = kll_pkg::WEIGHT_W;
  localparam int ML = kll_pkg::MAX_LEVELS;
  localparam int LD = kll_pkg::LEVEL_DEPTH;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;  // read entry pos-1 of target
  localparam logic [3:0] S_INS_CMP = 4'd2;  // compare, shift up or place
  localparam logic [3:0] S_CAP     = 4'd3;  // capacity multiply loop
  localparam logic [3:0] S_DECIDE  = 4'd4;
  localparam logic [3:0] S_CMP_RD  = 4'd5;  // read source entry j
  localparam logic [3:0] S_CMP_GO  = 4'd6;  // dispatch entry j
  localparam logic [3:0] S_Q_RD    = 4'd7;
  localparam logic [3:0] S_Q_ACC   = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;
  localparam logic [3:0] S_NEXT    = 4'd10;

  logic [3:0] state;

  // Configuration.
  logic [7:0]  top_capacity;
  logic [15:0] shrink_ratio;
  logic [15:0] lfsr;

  // Sketch state.
  logic [NW-1:0]   level_length [ML];
  logic [1:0]      coin_state [ML];
  logic [LW:0]     level_count;
  logic [WW-1:0]   item_count;
  logic            overflow_seen;

  // Level memory, one word per cycle read and written.
  logic [VW-1:0]   mem [ML*LD];
  logic [VW-1:0]   rd_data;
  logic [LW+PW-1:0] rd_addr;
  logic            wr_en;
  logic [LW+PW-1:0] wr_addr;
  logic [VW-1:0]   wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Working registers.
  logic [VW-1:0]   value;
  logic [LW-1:0]   lvl;        // level being checked or queried
  logic [LW-1:0]   tgt;        // level receiving an insert
  logic [NW-1:0]   pos;        // insert walk position
  logic [NW-1:0]   j;          // compaction / query index
  logic [NW-1:0]   n_kept;     // in-place compaction count
  logic [NW-1:0]   src_len;
  logic            in_place;
  logic            from_cmp;   // insert belongs to a compaction
  logic [23:0]     cap_v;
  logic [LW:0]     cap_steps;
  logic [WW-1:0]   sum;
  logic [NW-1:0]   q_cnt;
  logic            q_live;     // the last query read was a stored entry
  kll_pkg::result_t res_q;
  logic            res_valid;

  // Shared multiplier: one 24x16 product per cycle.
  logic [39:0] prod;
  assign prod = cap_v * shrink_ratio;

  logic [7:0] cap_int;
  logic [NW-1:0] cap_len;
  always_comb begin
    cap_int = cap_v[23:16];
    if (cap_int < 8'd2) begin
      cap_int = 8'd2;
    end
    cap_len = NW'(cap_int);
  end

  logic b_coin;
  assign b_coin = lfsr[0];

  logic [LW-1:0] lvl_up;
  assign lvl_up = lvl + LW'(1);

  // Rank add with saturation.
  logic [WW:0] acc_sum;
  assign acc_sum = {1'b0, sum} + ((WW+1)'(q_cnt) << lvl);

  assign req.ready = (state == S_IDLE) && !res_valid;
  assign res.valid = res_valid;
  assign res.payload = res_q;

  // Memory address and write port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {tgt, pos[PW-1:0]};
    wr_data = rd_data;
    rd_addr = {tgt, PW'(pos - NW'(1))};
    unique case (state)
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (pos != '0 && rd_data > value) begin
          wr_data = rd_data;
        end else begin
          wr_data = value;
        end
      end
      S_CMP_RD, S_Q_RD: begin
        rd_addr = {lvl, j[PW-1:0]};
      end
      S_CMP_GO: begin
        if (in_place) begin
          wr_en   = 1'b1;
          wr_addr = {lvl, n_kept[PW-1:0]};
          wr_data = rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      top_capacity  <= 8'd100;
      shrink_ratio  <= 16'd43691;
      lfsr          <= 16'd44257;
      level_count   <= (LW+1)'(1);
      item_count    <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
      for (int i = 0; i < ML; i++) begin
        level_length[i] <= '0;
        coin_state[i]   <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          kll_pkg::REG_TOP_CAPACITY: top_capacity <= cfg_data[7:0];
          kll_pkg::REG_SHRINK_RATIO: shrink_ratio <= cfg_data;
          kll_pkg::REG_RANDOM_SEED:  lfsr <= cfg_data;
          default: begin
          end
        endcase
      end
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            value <= req.payload.sample_value;
            lvl   <= '0;
            if (req.payload.command == kll_pkg::CMD_INSERT) begin
              if (item_count != {WW{1'b1}}) begin
                item_count <= item_count + WW'(1);
              end
              tgt      <= '0;
              from_cmp <= 1'b0;
              if (level_length[0] == NW'(LD)) begin
                overflow_seen <= 1'b1;
                state <= S_NEXT;
              end else begin
                pos   <= level_length[0];
                state <= S_INS_RD;
              end
            end else begin
              sum   <= '0;
              j     <= '0;
              q_cnt <= '0;
              state <= S_Q_RD;
            end
          end
        end
        S_INS_RD: begin
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          // An entry above the value shifts up; otherwise the value lands.
          if (pos != '0 && rd_data > value) begin
            pos   <= pos - NW'(1);
            state <= S_INS_RD;
          end else begin
            level_length[tgt] <= level_length[tgt] + NW'(1);
            state <= from_cmp ? S_CMP_RD : S_NEXT;
            if (from_cmp) begin
              j <= j + NW'(2);
            end
          end
        end
        S_NEXT: begin
          // Begin the check of level lvl: capacity from the top down.
          if ({1'b0, lvl} >= level_count) begin
            state <= S_IDLE;
          end else begin
            cap_v     <= {top_capacity, 16'd0};
            cap_steps <= level_count - (LW+1)'(1) - (LW+1)'(lvl);
            state     <= S_CAP;
          end
        end
        S_CAP: begin
          if (cap_steps == '0) begin
            state <= S_DECIDE;
          end else begin
            cap_v     <= prod[39:16];
            cap_steps <= cap_steps - (LW+1)'(1);
          end
        end
        S_DECIDE: begin
          src_len <= level_length[lvl];
          n_kept  <= '0;
          if (level_length[lvl] <= cap_len) begin
            lvl   <= lvl_up;
            state <= (lvl == LW'(ML-1)) ? S_IDLE : S_NEXT;
          end else begin
            if (coin_state[lvl] == 2'd0) begin
              j <= NW'(b_coin);
              coin_state[lvl] <= {1'b0, b_coin} + 2'd1;
              lfsr <= b_coin ? ((lfsr >> 1) ^ kll_pkg::LFSR_TAPS) : (lfsr >> 1);
            end else begin
              // The offset is the complement of the one drawn before.
              j <= NW'(coin_state[lvl][0]);
              coin_state[lvl] <= 2'd0;
            end
            in_place <= 1'b0;
            if ({1'b0, lvl} + (LW+1)'(1) >= level_count) begin
              if (level_count < (LW+1)'(ML)) begin
                level_count <= level_count + (LW+1)'(1);
                level_length[lvl_up] <= '0;
                coin_state[lvl_up]   <= '0;
              end else begin
                in_place      <= 1'b1;
                overflow_seen <= 1'b1;
              end
            end
            state <= S_CMP_RD;
          end
        end
        S_CMP_RD: begin
          if (j >= src_len) begin
            level_length[lvl] <= in_place ? n_kept : '0;
            lvl   <= lvl_up;
            state <= (lvl == LW'(ML-1)) ? S_IDLE : S_NEXT;
          end else begin
            state <= S_CMP_GO;
          end
        end
        S_CMP_GO: begin
          if (in_place) begin
            n_kept <= n_kept + NW'(1);
            j      <= j + NW'(2);
            state  <= S_CMP_RD;
          end else if (level_length[lvl_up] == NW'(LD)) begin
            overflow_seen <= 1'b1;
            j     <= j + NW'(2);
            state <= S_CMP_RD;
          end else begin
            value    <= rd_data;
            tgt      <= lvl_up;
            pos      <= level_length[lvl_up];
            from_cmp <= 1'b1;
            state    <= S_INS_RD;
          end
        end
        S_Q_RD: begin
          if ({1'b0, lvl} >= level_count) begin
            state <= S_OUT;
          end else if (j >= level_length[lvl]) begin
            q_live <= 1'b0;
            state  <= S_Q_ACC;
          end else begin
            j      <= j + NW'(1);
            q_live <= 1'b1;
            state  <= S_Q_ACC;
          end
        end
        S_Q_ACC: begin
          // rd_data holds entry j-1 when the previous read was in range.
          if (q_live) begin
            if (rd_data < value) begin
              q_cnt <= q_cnt + NW'(1);
            end
            state <= S_Q_RD;
          end else begin
            sum   <= acc_sum[WW] ? {WW{1'b1}} : acc_sum[WW-1:0];
            q_cnt <= '0;
            j     <= '0;
            lvl   <= lvl_up;
            state <= (lvl == LW'(ML-1)) ? S_OUT : S_Q_RD;
          end
        end
        S_OUT: begin
          res_q.rank_estimate <= sum;
          res_q.total_weight  <= item_count;
          res_q.levels_in_use <= kll_pkg::CNT_W'(level_count);
          res_q.overflow_flag <= overflow_seen;
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: test/kll_sketch_checker.sv
// ----------------------------------------------------------------------------
// kll_sketch_checker: scoreboard for the KLL quantile sketch
// Watches the request, result and register ports, keeps its own copy of the
// sketch levels and compares every query answer field by field.
// ----------------------------------------------------------------------------
module kll_sketch_checker
  import kll_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  request_t              req_payload,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  result_t               res_payload,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    answers_pending,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [WEIGHT_W-1:0] WEIGHT_SAT = '1;

  logic [7:0]             cap_top;
  logic [15:0]            ratio_q16;
  logic [VALUE_WIDTH-1:0] levels [MAX_LEVELS][LEVEL_DEPTH];
  int unsigned            fill [MAX_LEVELS];
  logic [1:0]             coin [MAX_LEVELS];
  int unsigned            num_levels;
  logic [WEIGHT_W-1:0]    inserts_seen;
  logic [15:0]            lfsr;
  logic                   overflow;
  result_t                expected_answers [$];

  assign answers_pending = expected_answers.size();

  function automatic longint unsigned capacity_of(int unsigned lvl);
    longint unsigned v;
    v = longint'(cap_top) << 16;
    for (int unsigned n = 0; n < num_levels - 1 - lvl; n++) begin
      v = (v * ratio_q16) >> 16;
    end
    v = v >> 16;
    return (v < 2) ? 2 : v;
  endfunction

  function automatic logic next_coin();
    logic b;
    b = lfsr[0];
    lfsr = lfsr >> 1;
    if (b) lfsr = lfsr ^ LFSR_TAPS;
    return b;
  endfunction

  function automatic void place_sorted(int unsigned lvl, logic [VALUE_WIDTH-1:0] x);
    int unsigned pos;
    int unsigned len;
    len = fill[lvl];
    pos = 0;
    if (len >= LEVEL_DEPTH) begin
      overflow = 1'b1;
      return;
    end
    while (pos < len && levels[lvl][pos] <= x) pos++;
    for (int unsigned j = len; j > pos; j--) levels[lvl][j] = levels[lvl][j-1];
    levels[lvl][pos] = x;
    fill[lvl] = len + 1;
  endfunction

  function automatic void compact_levels();
    int unsigned len;
    int unsigned off;
    int unsigned n;
    for (int unsigned i = 0; i < num_levels && i < MAX_LEVELS; i++) begin
      len = fill[i];
      if (len <= capacity_of(i)) continue;
      if (coin[i] == 2'd0) begin
        off = next_coin();
        coin[i] = 2'(off + 1);
      end else begin
        off = ((coin[i] - 2'd1) & 2'd1) ^ 1;
        coin[i] = 2'd0;
      end
      if (i + 1 >= num_levels) begin
        if (num_levels < MAX_LEVELS) begin
          num_levels++;
          fill[i+1] = 0;
          coin[i+1] = 2'd0;
        end else begin
          // The top level keeps its selected half in place and drops the rest.
          n = 0;
          for (int unsigned j = off; j < len; j += 2) begin
            levels[i][n] = levels[i][j];
            n++;
          end
          fill[i] = n;
          overflow = 1'b1;
          continue;
        end
      end
      for (int unsigned j = off; j < len; j += 2) place_sorted(i + 1, levels[i][j]);
      fill[i] = 0;
    end
  endfunction

  function automatic logic [WEIGHT_W-1:0] weighted_rank(logic [VALUE_WIDTH-1:0] x);
    longint unsigned sum;
    longint unsigned cnt;
    sum = 0;
    for (int unsigned i = 0; i < num_levels && i < MAX_LEVELS; i++) begin
      cnt = 0;
      for (int unsigned j = 0; j < fill[i]; j++) if (levels[i][j] < x) cnt++;
      sum += cnt << i;
      if (sum > WEIGHT_SAT) sum = WEIGHT_SAT;
    end
    return sum[WEIGHT_W-1:0];
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cap_top      = 8'd100;
      ratio_q16    = 16'd43691;
      lfsr         = 16'd44257;
      num_levels   = 1;
      inserts_seen = '0;
      overflow     = 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        fill[i] = 0;
        coin[i] = 2'd0;
      end
      expected_answers.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TOP_CAPACITY: cap_top = cfg_data[7:0];
          REG_SHRINK_RATIO: ratio_q16 = cfg_data;
          REG_RANDOM_SEED: lfsr = cfg_data;
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result %p", $time, res_payload);
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          if (want.rank_estimate !== res_payload.rank_estimate) begin
            $display("%0t: rank_estimate expected %0d actual %0d", $time,
                     want.rank_estimate, res_payload.rank_estimate);
            fail_count++;
          end
          if (want.total_weight !== res_payload.total_weight) begin
            $display("%0t: total_weight expected %0d actual %0d", $time,
                     want.total_weight, res_payload.total_weight);
            fail_count++;
          end
          if (want.levels_in_use !== res_payload.levels_in_use) begin
            $display("%0t: levels_in_use expected %0d actual %0d", $time,
                     want.levels_in_use, res_payload.levels_in_use);
            fail_count++;
          end
          if (want.overflow_flag !== res_payload.overflow_flag) begin
            $display("%0t: overflow_flag expected %0b actual %0b", $time,
                     want.overflow_flag, res_payload.overflow_flag);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        if (req_payload.command == CMD_INSERT) begin
          place_sorted(0, req_payload.sample_value);
          if (inserts_seen != WEIGHT_SAT) inserts_seen++;
          compact_levels();
        end else begin
          want.rank_estimate = weighted_rank(req_payload.sample_value);
          want.total_weight  = inserts_seen;
          want.levels_in_use = CNT_W'(num_levels);
          want.overflow_flag = overflow;
          expected_answers.push_back(want);
        end
      end
    end
  end
endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the KLL quantile sketch
// Drives inserts and rank queries under several register settings and with
// random gaps on both channels; the checker predicts and compares answers.
// ----------------------------------------------------------------------------
module tb_top;
  import kll_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 12_000_000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    answers_pending;
  int                    fail_count;
  int                    send_gap_pct;
  int                    take_gap_pct;
  longint                cycles = 0;

  kll_req_if req_ch();
  kll_res_if res_ch();

  kll_quantile_sketch u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kll_sketch_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_ch.valid),
    .req_ready       (req_ch.ready),
    .req_payload     (req_ch.payload),
    .res_valid       (res_ch.valid),
    .res_ready       (res_ch.ready),
    .res_payload     (res_ch.payload),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .answers_pending (answers_pending),
    .fail_count      (fail_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The result side stalls at random; the share of stalled cycles follows
  // the current idling mode, and is zero in the last mode.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // Watchdog: a hung handshake must not keep the run alive forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Writes one register; the enable is left high for the caller to drop
  // or to reuse for the next write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic load_settings(input int unsigned k, input int unsigned ratio,
                               input int unsigned lfsr_seed);
    write_reg(REG_TOP_CAPACITY, k);
    write_reg(REG_SHRINK_RATIO, ratio);
    write_reg(REG_RANDOM_SEED, lfsr_seed);
    cfg_write <= 1'b0;
  endtask

  // Sends one request: optional random gap first, then holds valid until
  // the block takes it. Ready is looked at on the falling edge, where all
  // inputs and registered outputs have settled for the coming rising edge.
  task automatic send_request(input logic cmd, input logic [VALUE_WIDTH-1:0] value);
    bit taken;
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid                <= 1'b1;
    req_ch.payload.command      <= cmd;
    req_ch.payload.sample_value <= value;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = req_ch.ready;
      @(posedge clk);
    end
  endtask

  // Lets every outstanding answer come back and any silent cascade finish,
  // so that registers are only written while the block is idle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (answers_pending != 0) @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Values either spread over the whole range or crowd into a narrow window
  // at the bottom or top, so duplicates and equal-value rank boundaries show up.
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(31);
      1: return 32'hFFFF_FFE0 | $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned k;
    int unsigned ratio;
    int unsigned lfsr_seed;
    rst                         <= 1'b1;
    cfg_write                   <= 1'b0;
    cfg_index                   <= '0;
    cfg_data                    <= '0;
    req_ch.valid                <= 1'b0;
    req_ch.payload.command      <= CMD_INSERT;
    req_ch.payload.sample_value <= '0;
    send_gap_pct                = 0;
    take_gap_pct                = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings: an empty sketch, the value
    // extremes, duplicates, and ranks right at and around stored values.
    send_request(CMD_QUERY, 32'h0);
    send_request(CMD_QUERY, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'h0);
    send_request(CMD_INSERT, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'h8000_0000);
    send_request(CMD_INSERT, 32'h7FFF_FFFF);
    send_request(CMD_INSERT, 32'h8000_0000);
    send_request(CMD_INSERT, 32'h5555_5555);
    send_request(CMD_INSERT, 32'hAAAA_AAAA);
    send_request(CMD_QUERY, 32'h0);
    send_request(CMD_QUERY, 32'h1);
    send_request(CMD_QUERY, 32'h8000_0000);
    send_request(CMD_QUERY, 32'h8000_0001);
    send_request(CMD_QUERY, 32'hFFFF_FFFF);
    drain();

    // Smallest capacities right away: a handful of inserts forces cascades
    // and new levels, with the lowest ratio and the top seed value.
    load_settings(2, 32768, 65535);
    for (int i = 0; i < 9; i++) send_request(CMD_INSERT, 32'(i * 3));
    send_request(CMD_QUERY, 32'd7);
    send_request(CMD_QUERY, 32'hFFFF_FFFF);
    drain();

    // Random phases, each under its own settings; the idling modes follow
    // one another: slow result side, then slow request side, then none.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin k = 128; ratio = 65535; lfsr_seed = 1; end
        1: begin k = 2; ratio = 32768; lfsr_seed = 65535; end
        2: begin k = 100; ratio = 43691; lfsr_seed = 44257; end
        3: begin k = 4; ratio = 65535; lfsr_seed = $urandom_range(65535, 1); end
        default: begin
          k = $urandom_range(128, 2);
          ratio = $urandom_range(65535, 32768);
          lfsr_seed = $urandom_range(65535, 1);
        end
      endcase
      if (phase < 2) begin
        send_gap_pct = 7;
        take_gap_pct = 70;
      end else if (phase < 4) begin
        send_gap_pct = 70;
        take_gap_pct = 7;
      end else begin
        send_gap_pct = 0;
        take_gap_pct = 0;
      end
      load_settings(k, ratio, lfsr_seed);
      for (int n = 0; n < 115; n++) begin
        if ($urandom_range(99) < 30) send_request(CMD_QUERY, pick_value());
        else send_request(CMD_INSERT, pick_value());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
design/kll_pkg.sv
design/kll_if.sv
design/kll_quantile_sketch.sv
test/kll_sketch_checker.sv
test/tb_top.sv
